FILE: design/bapms_pkg.sv
// Package: shared types, codes and constants of the battery-aware power mode selector.
`timescale 1ns / 1ps
`default_nettype none
package bapms_pkg;

  // Power mode codes as reported on the result channel
  typedef enum logic [3:0] {
    MODE_NONE = 4'd0,
    MODE_C0   = 4'd1,
    MODE_C1   = 4'd2,
    MODE_C2   = 4'd3,
    MODE_C3   = 4'd4,
    MODE_M4   = 4'd5,
    MODE_I5   = 4'd6,
    MODE_L6   = 4'd7,
    MODE_L7   = 4'd8
  } mode_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_POWERSAVE     = 3'd0,
    CFG_CUTOFF_V      = 3'd1,
    CFG_RESTORE_V     = 3'd2,
    CFG_LOW_V         = 3'd3,
    CFG_FEATURES      = 3'd4,
    CFG_REPORT_PERIOD = 3'd5,
    CFG_CUTOFF_SLEEP  = 3'd6
  } cfg_idx_t;

  // Power-save policy codes (code 3 selects nothing)
  localparam logic [1:0] POL_NONE   = 2'd0;
  localparam logic [1:0] POL_NORMAL = 2'd1;
  localparam logic [1:0] POL_AGGR   = 2'd2;

  // Rail patterns: bit0 sensor, bit1 radio, bit2 modem, bit3 card
  localparam logic [3:0] RAILS_C0      = 4'hF;
  localparam logic [3:0] RAILS_C1      = 4'hB;
  localparam logic [3:0] RAILS_C2      = 4'hA;
  localparam logic [3:0] RAILS_C3      = 4'hE;
  localparam logic [3:0] RAILS_M4      = 4'h9;
  localparam logic [3:0] RAILS_M4_KEEP = 4'hD;
  localparam logic [3:0] RAILS_OFF     = 4'h0;
  localparam logic [3:0] RAILS_L6      = 4'h4;

  // Reading and countdown constants
  localparam logic [15:0] MIN_READING  = 16'd678;
  localparam logic [15:0] BAD_READING  = 16'hFFFF;
  localparam logic [7:0]  CD_IDLE      = 8'hFF;
  localparam logic [7:0]  CD_START     = 8'd60;
  localparam logic [7:0]  CD_STEP      = 8'd10;
  localparam logic [7:0]  CD_HALF      = 8'd30;
  localparam logic [7:0]  PERIOD_SPLIT = 8'd5;
  localparam logic [15:0] SLEEP_TRIM_2 = 16'd120;
  localparam logic [15:0] SLEEP_TRIM_1 = 16'd60;

  // Register reset values
  localparam logic [7:0]  PERIOD_RST       = 8'd10;
  localparam logic [10:0] CUTOFF_SLEEP_RST = 11'd20;

  typedef struct packed {
    logic [1:0]  save_policy;
    logic [15:0] cutoff_voltage;
    logic [15:0] restore_voltage;
    logic [15:0] low_voltage;
    logic [3:0]  feature_bits;
    logic [7:0]  report_period_minutes;
    logic [10:0] cutoff_sleep_minutes;
  } cfg_t;

  typedef struct packed {
    logic low;
    logic cutoff;
  } flags_t;

  typedef struct packed {
    mode_t      mode;
    logic [3:0] rails;
    flags_t     flags;
    logic [7:0] countdown;
  } state_t;

  typedef struct packed {
    logic signed [15:0] minutes_left;
    logic [15:0]        battery_reading;
    logic               clock_ok;
  } item_t;

  typedef struct packed {
    mode_t       mode_code;
    logic [3:0]  rails;
    logic        sleep_request;
    logic [15:0] sleep_seconds;
    logic        reinit_request;
    logic        flags_changed;
    logic        cutoff_flag;
    logic        low_flag;
    logic [15:0] reported_reading;
  } result_t;

endpackage
`default_nettype wire

FILE: design/bapms_in_if.sv
// Interface: input channel carrying one poll tick.
`timescale 1ns / 1ps
`default_nettype none
interface bapms_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] minutes_left;
  logic [15:0]        battery_reading;
  logic               clock_ok;

  modport source (output valid, output minutes_left, output battery_reading,
                  output clock_ok, input ready);
  modport sink (input valid, input minutes_left, input battery_reading,
                input clock_ok, output ready);
endinterface
`default_nettype wire

FILE: design/bapms_out_if.sv
// Interface: result channel carrying one mode decision.
`timescale 1ns / 1ps
`default_nettype none
interface bapms_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode_code;
  logic        rail_sensor;
  logic        rail_radio;
  logic        rail_modem;
  logic        rail_card;
  logic        sleep_request;
  logic [15:0] sleep_seconds;
  logic        reinit_request;
  logic        flags_changed;
  logic        cutoff_flag;
  logic        low_flag;
  logic [15:0] reported_reading;

  modport source (output valid, output mode_code, output rail_sensor,
                  output rail_radio, output rail_modem, output rail_card,
                  output sleep_request, output sleep_seconds,
                  output reinit_request, output flags_changed,
                  output cutoff_flag, output low_flag,
                  output reported_reading, input ready);
  modport sink (input valid, input mode_code, input rail_sensor,
                input rail_radio, input rail_modem, input rail_card,
                input sleep_request, input sleep_seconds,
                input reinit_request, input flags_changed,
                input cutoff_flag, input low_flag,
                input reported_reading, output ready);
endinterface
`default_nettype wire

FILE: design/battery_aware_power_mode_selector.sv
// Top level: battery-aware power mode selector with input and result registers.
//
//   channel  | direction | handshake           | payload
//   in_ch    | in        | valid/ready         | minutes_left, battery_reading, clock_ok
//   out_ch   | out       | valid/ready         | mode_code, rails, sleep, reinit, flags, reading
//   cfg_*    | in        | cfg_we, no stall    | cfg_idx, cfg_data (16 bits)
//
// An input transfer loads the input register, and the decision moves into the result
// register when the decision stage advances.
// One tick per cycle is sustained while the result channel does not stall; mode, rail,
// flag and countdown state update as the result register loads, so the next tick sees them at once.
// A stalled result holds the decision stage; the input register still takes a
// tick while empty or draining. rst_n (synchronous) clears state and all valids.
`timescale 1ns / 1ps
`default_nettype none
module battery_aware_power_mode_selector (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [15:0] cfg_data,
  bapms_in_if.sink         in_ch,
  bapms_out_if.source      out_ch
);

  bapms_pkg::cfg_t     cfg;
  bapms_pkg::state_t   st_r;
  bapms_pkg::state_t   st_nxt;
  bapms_pkg::item_t    item_r;
  bapms_pkg::item_t    item_nxt;
  bapms_pkg::result_t  res_nxt;
  bapms_pkg::result_t  res_r;
  logic                in_vld_r;
  logic                out_vld_r;
  logic                advance;

  bapms_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  bapms_core u_core (
    .cfg    (cfg),
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // decision stage moves when the input register holds a tick and the result register is free or being taken
  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;

  assign item_nxt.minutes_left    = in_ch.minutes_left;
  assign item_nxt.battery_reading = in_ch.battery_reading;
  assign item_nxt.clock_ok        = in_ch.clock_ok;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r <= item_nxt;
    end
  end

  // mode, rails, flags and countdown
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode      <= bapms_pkg::MODE_NONE;
      st_r.rails     <= bapms_pkg::RAILS_OFF;
      st_r.flags     <= '0;
      st_r.countdown <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  // result channel
  assign out_ch.valid            = out_vld_r;
  assign out_ch.mode_code        = res_r.mode_code;
  assign out_ch.rail_sensor      = res_r.rails[0];
  assign out_ch.rail_radio       = res_r.rails[1];
  assign out_ch.rail_modem       = res_r.rails[2];
  assign out_ch.rail_card        = res_r.rails[3];
  assign out_ch.sleep_request    = res_r.sleep_request;
  assign out_ch.sleep_seconds    = res_r.sleep_seconds;
  assign out_ch.reinit_request   = res_r.reinit_request;
  assign out_ch.flags_changed    = res_r.flags_changed;
  assign out_ch.cutoff_flag      = res_r.cutoff_flag;
  assign out_ch.low_flag         = res_r.low_flag;
  assign out_ch.reported_reading = res_r.reported_reading;

`ifndef SYNTH
  // a sleep request only comes with a sleep mode
  a_sleep_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.sleep_request |->
      (res_r.mode_code == bapms_pkg::MODE_L6) || (res_r.mode_code == bapms_pkg::MODE_L7))
    else $error("sleep request outside a sleep mode");

  // no sleep length without a sleep request
  a_sleep_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !res_r.sleep_request |-> res_r.sleep_seconds == '0)
    else $error("sleep length without request");

  // cutoff always ends in L7 or I5 with every rail off
  a_cutoff_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.cutoff_flag |-> (res_r.rails == bapms_pkg::RAILS_OFF) &&
      ((res_r.mode_code == bapms_pkg::MODE_L7) || (res_r.mode_code == bapms_pkg::MODE_I5)))
    else $error("cutoff with rails on or wrong mode");

  // reinit only on entry to C0, C1 or M4, and state tracks the result
  a_reinit_mode: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_nxt.reinit_request |=>
      ((st_r.mode == bapms_pkg::MODE_C0) || (st_r.mode == bapms_pkg::MODE_C1) ||
       (st_r.mode == bapms_pkg::MODE_M4)) && (st_r.mode != $past(st_r.mode)))
    else $error("reinit without entry to C0, C1 or M4");
`endif

endmodule
`default_nettype wire

FILE: design/bapms_cfg.sv
// Module: configuration register bank written through the plain write port.
`timescale 1ns / 1ps
`default_nettype none
module bapms_cfg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_idx,
  input  wire logic [15:0]   cfg_data,
  output bapms_pkg::cfg_t    cfg
);

  bapms_pkg::cfg_t cfg_r;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.save_policy           <= bapms_pkg::POL_NONE;
      cfg_r.cutoff_voltage        <= '0;
      cfg_r.restore_voltage       <= '0;
      cfg_r.low_voltage           <= '0;
      cfg_r.feature_bits          <= '0;
      cfg_r.report_period_minutes <= bapms_pkg::PERIOD_RST;
      cfg_r.cutoff_sleep_minutes  <= bapms_pkg::CUTOFF_SLEEP_RST;
    end else if (cfg_we) begin
      unique case (bapms_pkg::cfg_idx_t'(cfg_idx))
        bapms_pkg::CFG_POWERSAVE:     cfg_r.save_policy           <= cfg_data[1:0];
        bapms_pkg::CFG_CUTOFF_V:      cfg_r.cutoff_voltage        <= cfg_data;
        bapms_pkg::CFG_RESTORE_V:     cfg_r.restore_voltage       <= cfg_data;
        bapms_pkg::CFG_LOW_V:         cfg_r.low_voltage           <= cfg_data;
        bapms_pkg::CFG_FEATURES:      cfg_r.feature_bits          <= cfg_data[3:0];
        bapms_pkg::CFG_REPORT_PERIOD: cfg_r.report_period_minutes <= cfg_data[7:0];
        bapms_pkg::CFG_CUTOFF_SLEEP:  cfg_r.cutoff_sleep_minutes  <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

FILE: design/bapms_core.sv
// Module: single-pass decision logic: battery flags, countdown, mode tree and mode switch.
`timescale 1ns / 1ps
`default_nettype none
module bapms_core (
  input  wire bapms_pkg::cfg_t    cfg,
  input  wire bapms_pkg::state_t  st,
  input  wire bapms_pkg::item_t   item,
  output bapms_pkg::state_t       st_nxt,
  output bapms_pkg::result_t      res
);

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_GO,
    ACT_SLEEP
  } act_t;

  logic [15:0]        vb;
  bapms_pkg::flags_t  flags_n;
  logic [1:0]         policy;
  logic [7:0]         cd_dec;
  logic [7:0]         cd_new;
  logic               cd_le_half;
  logic               min_gt1;
  logic               min_gt2;
  logic               min_eq1;
  logic               wx;
  logic               gsm;
  logic               digi;
  logic               long_period;
  logic [3:0]         rails_m4;
  logic [15:0]        per_w;
  logic [15:0]        per_x60;
  logic [15:0]        secs_trim2;
  logic [15:0]        secs_trim1;
  logic [15:0]        csm_w;
  logic [15:0]        cut_secs;
  act_t               act;
  bapms_pkg::mode_t   tgt_mode;
  logic [3:0]         tgt_rails;
  logic               tgt_reinit;
  logic [15:0]        tgt_secs;
  bapms_pkg::mode_t   cur_mode;
  logic               sleep_req;
  logic [15:0]        sleep_len;
  logic               reinit;

  // implausible reading substitution
  assign vb = (item.battery_reading < bapms_pkg::MIN_READING) ?
              bapms_pkg::BAD_READING : item.battery_reading;

  // hysteretic battery flags
  always_comb begin
    if (vb > cfg.restore_voltage) begin
      flags_n = '0;
    end else begin
      flags_n.cutoff = st.flags.cutoff | (vb <= cfg.cutoff_voltage);
      flags_n.low    = st.flags.low | (vb <= cfg.low_voltage);
    end
  end

  assign policy = flags_n.low ? bapms_pkg::POL_AGGR : cfg.save_policy;

  // minute compares and last-minute seconds countdown
  assign min_gt1 = item.minutes_left > 16'sd1;
  assign min_gt2 = item.minutes_left > 16'sd2;
  assign min_eq1 = item.minutes_left == 16'sd1;
  assign cd_dec  = (st.countdown != bapms_pkg::CD_IDLE) ?
                   st.countdown - bapms_pkg::CD_STEP : st.countdown;

  always_comb begin
    priority if (min_gt1) begin
      cd_new = bapms_pkg::CD_IDLE;
    end else if (min_eq1 && (cd_dec == bapms_pkg::CD_IDLE)) begin
      cd_new = bapms_pkg::CD_START;
    end else begin
      cd_new = cd_dec;
    end
  end

  assign cd_le_half = $signed(cd_new) <= $signed(bapms_pkg::CD_HALF);

  // feature bits
  assign wx          = cfg.feature_bits[0];
  assign gsm         = cfg.feature_bits[1];
  assign digi        = cfg.feature_bits[2];
  assign rails_m4    = cfg.feature_bits[3] ? bapms_pkg::RAILS_M4_KEEP : bapms_pkg::RAILS_M4;
  assign long_period = cfg.report_period_minutes >= bapms_pkg::PERIOD_SPLIT;

  // sleep lengths, all modulo 2^16; x*60 as (x<<6)-(x<<2)
  assign per_w      = 16'(cfg.report_period_minutes);
  assign per_x60    = (per_w << 6) - (per_w << 2);
  assign secs_trim2 = per_x60 - bapms_pkg::SLEEP_TRIM_2;
  assign secs_trim1 = per_x60 - bapms_pkg::SLEEP_TRIM_1;
  assign csm_w      = 16'(cfg.cutoff_sleep_minutes);
  assign cut_secs   = (csm_w << 6) - (csm_w << 2);

  // decision tree: pick the target mode and how it is entered
  always_comb begin
    act        = ACT_NONE;
    tgt_mode   = bapms_pkg::MODE_NONE;
    tgt_rails  = bapms_pkg::RAILS_OFF;
    tgt_reinit = 1'b0;
    tgt_secs   = '0;
    priority if (flags_n.cutoff) begin
      act      = ACT_SLEEP;
      tgt_mode = bapms_pkg::MODE_L7;
      tgt_secs = cut_secs;
    end else if ((policy <= bapms_pkg::POL_AGGR) && !wx) begin
      act = ACT_GO; tgt_mode = bapms_pkg::MODE_C2; tgt_rails = bapms_pkg::RAILS_C2;
    end else if (policy == bapms_pkg::POL_NONE) begin
      act = ACT_GO; tgt_reinit = 1'b1;
      priority if (gsm) begin
        tgt_mode = bapms_pkg::MODE_C0; tgt_rails = bapms_pkg::RAILS_C0;
      end else if (digi) begin
        tgt_mode = bapms_pkg::MODE_C1; tgt_rails = bapms_pkg::RAILS_C1;
      end else if (min_gt2) begin
        tgt_mode = bapms_pkg::MODE_M4; tgt_rails = rails_m4;
      end else begin
        tgt_mode = bapms_pkg::MODE_C0; tgt_rails = bapms_pkg::RAILS_C0;
      end
    end else if (policy == bapms_pkg::POL_NORMAL) begin
      act = ACT_GO;
      priority if (gsm && digi) begin
        priority if (!min_gt1) begin
          tgt_mode = bapms_pkg::MODE_C0; tgt_rails = bapms_pkg::RAILS_C0; tgt_reinit = 1'b1;
        end else if (long_period) begin
          tgt_mode = bapms_pkg::MODE_C2; tgt_rails = bapms_pkg::RAILS_C2;
        end else begin
          tgt_mode = bapms_pkg::MODE_C3; tgt_rails = bapms_pkg::RAILS_C3;
        end
      end else if (gsm) begin
        tgt_reinit = 1'b1;
        if (min_gt1) begin
          tgt_mode = bapms_pkg::MODE_M4; tgt_rails = rails_m4;
        end else begin
          tgt_mode = bapms_pkg::MODE_C0; tgt_rails = bapms_pkg::RAILS_C0;
        end
      end else if (digi) begin
        if (min_gt1) begin
          tgt_mode = bapms_pkg::MODE_C2; tgt_rails = bapms_pkg::RAILS_C2;
        end else begin
          tgt_mode = bapms_pkg::MODE_C1; tgt_rails = bapms_pkg::RAILS_C1; tgt_reinit = 1'b1;
        end
      end else begin
        if (min_gt2) begin
          act = ACT_SLEEP; tgt_mode = bapms_pkg::MODE_L7; tgt_secs = secs_trim2;
        end else begin
          tgt_mode = bapms_pkg::MODE_C0; tgt_rails = bapms_pkg::RAILS_C0; tgt_reinit = 1'b1;
        end
      end
    end else if (policy == bapms_pkg::POL_AGGR) begin
      act = ACT_GO;
      priority if (gsm && digi) begin
        if (min_gt1) begin
          tgt_mode = bapms_pkg::MODE_C2; tgt_rails = bapms_pkg::RAILS_C2;
        end else begin
          tgt_mode = bapms_pkg::MODE_C0; tgt_rails = bapms_pkg::RAILS_C0; tgt_reinit = 1'b1;
        end
      end else if (gsm) begin
        priority if (min_gt1) begin
          act       = ACT_SLEEP;
          tgt_secs  = secs_trim1;
          tgt_mode  = long_period ? bapms_pkg::MODE_L7 : bapms_pkg::MODE_L6;
          tgt_rails = long_period ? bapms_pkg::RAILS_OFF : bapms_pkg::RAILS_L6;
        end else if (!long_period || cd_le_half) begin
          tgt_mode = bapms_pkg::MODE_C0; tgt_rails = bapms_pkg::RAILS_C0; tgt_reinit = 1'b1;
        end else begin
          tgt_mode = bapms_pkg::MODE_M4; tgt_rails = rails_m4; tgt_reinit = 1'b1;
        end
      end else if (digi) begin
        if (min_gt1) begin
          tgt_mode = bapms_pkg::MODE_C2; tgt_rails = bapms_pkg::RAILS_C2;
        end else begin
          tgt_mode = bapms_pkg::MODE_C1; tgt_rails = bapms_pkg::RAILS_C1; tgt_reinit = 1'b1;
        end
      end else begin
        // weather only: last half minute holds C1 without reinit
        priority if (min_gt1) begin
          act = ACT_SLEEP; tgt_mode = bapms_pkg::MODE_L7; tgt_secs = secs_trim1;
        end else if (cd_le_half) begin
          tgt_mode = bapms_pkg::MODE_C1; tgt_rails = bapms_pkg::RAILS_C1;
        end else begin
          tgt_mode = bapms_pkg::MODE_M4; tgt_rails = rails_m4; tgt_reinit = 1'b1;
        end
      end
    end
  end

  // mode switch: cutoff clears the mode first, so sleep (or idle) entry always fires
  assign cur_mode = flags_n.cutoff ? bapms_pkg::MODE_NONE : st.mode;

  always_comb begin
    st_nxt.mode      = cur_mode;
    st_nxt.rails     = st.rails;
    st_nxt.flags     = flags_n;
    st_nxt.countdown = flags_n.cutoff ? st.countdown : cd_new;
    sleep_req        = 1'b0;
    sleep_len        = '0;
    reinit           = 1'b0;
    unique case (act)
      ACT_GO: begin
        if (cur_mode != tgt_mode) begin
          st_nxt.mode  = tgt_mode;
          st_nxt.rails = tgt_rails;
          reinit       = tgt_reinit;
        end
      end
      ACT_SLEEP: begin
        priority if (!item.clock_ok) begin
          // no timed wakeup possible: idle instead
          if (cur_mode != bapms_pkg::MODE_I5) begin
            st_nxt.mode  = bapms_pkg::MODE_I5;
            st_nxt.rails = bapms_pkg::RAILS_OFF;
          end
        end else if (cur_mode != tgt_mode) begin
          st_nxt.mode  = tgt_mode;
          st_nxt.rails = tgt_rails;
          sleep_req    = 1'b1;
          sleep_len    = tgt_secs;
        end
      end
      default: ;
    endcase
  end

  // result fields
  always_comb begin
    res.mode_code        = st_nxt.mode;
    res.rails            = st_nxt.rails;
    res.sleep_request    = sleep_req;
    res.sleep_seconds    = sleep_len;
    res.reinit_request   = reinit;
    res.flags_changed    = flags_n != st.flags;
    res.cutoff_flag      = flags_n.cutoff;
    res.low_flag         = flags_n.low;
    res.reported_reading = vb;
  end

endmodule
`default_nettype wire
